@@ src/qdec_pkg.sv @@
// qdec_pkg: shared types and constants of the quadrature decoder with speed
// used by the channel interfaces, the register port, the divider and the top level
// no dependencies

package qdec_pkg;

	// counter width, counters wrap modulo 2^COUNT_BITS (8 to 32)
	localparam int COUNT_BITS = 32;

	// payload widths
	localparam int TIME_W  = 32;
	localparam int DIST_W  = 32;
	localparam int SPEED_W = 32;
	localparam int FACTOR_W = 16;
	localparam int DIR_W   = 2;

	// speed divider: (distance << 16) / elapsed
	localparam int FRAC_W     = 16;
	localparam int DIVIDEND_W = DIST_W + FRAC_W;
	localparam int DIVISOR_W  = TIME_W;
	localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

	// register port
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;
	localparam int REG_IDX_W = PADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_DIST_PER_COUNT = '0;
	localparam logic [FACTOR_W-1:0]  FACTOR_RESET = FACTOR_W'(1);

	// input item kinds
	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_CLEAR  = 1'b1;

	// step classification codes
	localparam logic [DIR_W-1:0] STEP_NONE   = 2'd0;
	localparam logic [DIR_W-1:0] STEP_FWD    = 2'd1;
	localparam logic [DIR_W-1:0] STEP_BWD    = 2'd2;
	localparam logic [DIR_W-1:0] STEP_GLITCH = 2'd3;

	// latched direction codes
	localparam logic [DIR_W-1:0] DIR_UNKNOWN = 2'd0;
	localparam logic [DIR_W-1:0] DIR_FWD     = 2'd1;
	localparam logic [DIR_W-1:0] DIR_BWD     = 2'd2;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_OUT
	} qdec_state_t;

endpackage

@@ src/qdec_if.sv @@
// qdec_if: valid/ready channel interfaces for sample items and result items
// depends on qdec_pkg

interface qdec_in_if
	import qdec_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              kind;
	logic              line_a;
	logic              line_b;
	logic [TIME_W-1:0] now_us;

	modport source (output valid, kind, line_a, line_b, now_us, input ready);
	modport sink (input valid, kind, line_a, line_b, now_us, output ready);
endinterface

interface qdec_out_if
	import qdec_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [DIR_W-1:0]   step_dir;
	logic [31:0]        forward_steps;
	logic [31:0]        backward_steps;
	logic [DIST_W-1:0]  distance_um;
	logic [SPEED_W-1:0] speed_q16;
	logic [DIR_W-1:0]   last_dir;

	modport source (output valid, step_dir, forward_steps, backward_steps, distance_um,
		speed_q16, last_dir, input ready);
	modport sink (input valid, step_dir, forward_steps, backward_steps, distance_um,
		speed_q16, last_dir, output ready);
endinterface

@@ src/qdec_apb.sv @@
// qdec_apb: APB register port holding the distance-per-count factor
// depends on qdec_pkg

module qdec_apb
	import qdec_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0]  prdata,
	output logic                pready,
	output logic [FACTOR_W-1:0] factor
);

	logic [FACTOR_W-1:0] factor_q;
	logic                sel_factor;

	assign pready     = 1'b1;
	assign sel_factor = (paddr[PADDR_W-1:2] == REG_DIST_PER_COUNT);

	// register write in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_q <= FACTOR_RESET;
		end else if (psel && penable && pwrite && pready && sel_factor) begin
			factor_q <= pwdata[FACTOR_W-1:0];
		end
	end

	// read back
	assign prdata = sel_factor ? PDATA_W'(factor_q) : '0;
	assign factor = factor_q;

endmodule

@@ src/qdec_div.sv @@
// qdec_div: restoring divider, one quotient bit per cycle
// depends on qdec_pkg

module qdec_div
	import qdec_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  busy,
	output logic                  done,
	output logic [DIVIDEND_W-1:0] quotient
);

	logic                  busy_q;
	logic                  done_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  dvs_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W:0]    rem_sh;
	logic                  ge;

	// trial subtract on the shifted remainder
	assign rem_sh = {rem_q, quo_q[DIVIDEND_W-1]};
	assign ge     = (rem_sh >= {1'b0, dvs_q});

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIVIDEND_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath, dividend shifts out as quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? DIVISOR_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[DIVISOR_W-1:0];
			quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q)
		else $error("divider not busy after start");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(busy_q) && !busy_q))
		else $error("divider done without a finished run");
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !start)
		else $error("divider restarted while busy");

endmodule

@@ src/quadrature_decoder_with_speed.sv @@
// quadrature_decoder_with_speed: top level, step classification, counters and sequencer
// depends on qdec_pkg, qdec_if, qdec_apb and qdec_div

// Decodes sampled encoder lines A and B into forward, backward and glitch
// steps, keeps forward and backward counts, and reports distance (forward
// count times the distance-per-count register) and speed in micrometers per
// microsecond as unsigned Q16.16, saturating at all ones on zero elapsed time
// or overflow. One item is handled at a time: a line sample passes from
// acceptance through the 32 x 16 distance multiply, the divider load, the
// bit-per-cycle restoring divide of the 48-bit scaled distance by the 32-bit
// elapsed time, and the saturation and latching of the quotient before the
// result is offered, while a clear item goes straight to its result without
// a divide. A new item is accepted in the cycle after the result has been taken.

module quadrature_decoder_with_speed
	import qdec_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	qdec_in_if.sink             sample,
	qdec_out_if.source          result,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0]  prdata,
	output logic                pready
);

	qdec_state_t state_q, state_d;

	logic                  prev_a_q, prev_b_q, prev_valid_q;
	logic [COUNT_BITS-1:0] fwd_q, bwd_q;
	logic [TIME_W-1:0]     start_time_q;
	logic [DIR_W-1:0]      dir_q;
	logic [DIR_W-1:0]      step_q;
	logic [TIME_W-1:0]     elapsed_q;
	logic [DIST_W-1:0]     dist_q;
	logic [SPEED_W-1:0]    speed_q;

	logic [FACTOR_W-1:0]   factor;
	logic                  in_acc, out_acc;
	logic                  div_start, div_busy, div_done;
	logic [DIVIDEND_W-1:0] div_quo;
	logic                  is_fwd, is_bwd, changed;
	logic [DIST_W-1:0]     product;

	qdec_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.factor  (factor)
	);

	qdec_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({dist_q, FRAC_W'(0)}),
		.divisor  (elapsed_q),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	// transition rule against the previous levels
	always_comb begin
		is_fwd  = (sample.line_a == prev_a_q && sample.line_b != prev_b_q
			&& sample.line_b == sample.line_a)
			|| (prev_a_q == prev_b_q && sample.line_a != prev_a_q);
		is_bwd  = (sample.line_b == prev_b_q && sample.line_a != prev_a_q
			&& sample.line_a == sample.line_b)
			|| (prev_b_q == prev_a_q && sample.line_b != prev_b_q);
		changed = (sample.line_a != prev_a_q) || (sample.line_b != prev_b_q);
	end

	// distance, low bits of count times factor
	assign product = DIST_W'(DIST_W'(fwd_q) * DIST_W'(factor));

	assign in_acc  = sample.valid && sample.ready;
	assign out_acc = result.valid && result.ready;

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and handshake outputs
	always_comb begin
		state_d      = state_q;
		sample.ready = 1'b0;
		result.valid = 1'b0;
		div_start    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				sample.ready = 1'b1;
				if (sample.valid) begin
					state_d = (sample.kind == KIND_CLEAR) ? ST_OUT : ST_MUL;
				end
			end
			ST_MUL: begin
				state_d = ST_DIV_GO;
			end
			ST_DIV_GO: begin
				div_start = 1'b1;
				state_d   = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (div_done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				result.valid = 1'b1;
				if (result.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_a_q     <= 1'b0;
			prev_b_q     <= 1'b0;
			prev_valid_q <= 1'b0;
			fwd_q        <= '0;
			bwd_q        <= '0;
			start_time_q <= '0;
			dir_q        <= DIR_UNKNOWN;
		end else if (in_acc) begin
			if (sample.kind == KIND_CLEAR) begin
				fwd_q        <= '0;
				bwd_q        <= '0;
				start_time_q <= sample.now_us;
			end else begin
				prev_a_q     <= sample.line_a;
				prev_b_q     <= sample.line_b;
				prev_valid_q <= 1'b1;
				if (prev_valid_q && is_fwd) begin
					fwd_q <= fwd_q + 1'b1;
					dir_q <= DIR_FWD;
				end else if (prev_valid_q && is_bwd) begin
					bwd_q <= bwd_q + 1'b1;
					dir_q <= DIR_BWD;
				end
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			elapsed_q <= sample.now_us - start_time_q;
			if (sample.kind == KIND_CLEAR) begin
				step_q  <= STEP_NONE;
				dist_q  <= '0;
				speed_q <= '0;
			end else if (!prev_valid_q) begin
				step_q <= STEP_NONE;
			end else if (is_fwd) begin
				step_q <= STEP_FWD;
			end else if (is_bwd) begin
				step_q <= STEP_BWD;
			end else if (changed) begin
				step_q <= STEP_GLITCH;
			end else begin
				step_q <= STEP_NONE;
			end
		end
		if (state_q == ST_MUL) begin
			dist_q <= product;
		end
		// saturate on zero elapsed time or a quotient above 32 bits
		if (div_done) begin
			if (elapsed_q == '0 || div_quo[DIVIDEND_W-1:SPEED_W] != '0) begin
				speed_q <= '1;
			end else begin
				speed_q <= div_quo[SPEED_W-1:0];
			end
		end
	end

	assign result.step_dir       = step_q;
	assign result.forward_steps  = 32'(fwd_q);
	assign result.backward_steps = 32'(bwd_q);
	assign result.distance_um    = dist_q;
	assign result.speed_q16      = speed_q;
	assign result.last_dir       = dir_q;

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		!(sample.ready && result.valid))
		else $error("item accepted while a result is pending");
	a_clear_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && sample.kind == KIND_CLEAR) |=>
		(result.valid && fwd_q == '0 && bwd_q == '0 && speed_q == '0))
		else $error("clear item did not give a zeroed result");
	a_div_done_out: assert property (@(posedge clk) disable iff (!arst_n)
		(div_done && state_q == ST_DIV_WAIT) |=> result.valid)
		else $error("speed result not offered after the divide");
	a_div_only_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> (state_q == ST_DIV_WAIT))
		else $error("divider running outside the wait state");
	a_dir_latch: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && sample.kind == KIND_SAMPLE && prev_valid_q && is_fwd) |=> dir_q == DIR_FWD)
		else $error("direction not latched on a forward step");

endmodule
